FILE: hw/rtl/esrs_pkg.sv
`timescale 1ns / 1ps

package esrs_pkg;

  localparam int FLOORS  = 4;
  localparam int FLOOR_W = $clog2(FLOORS);

  typedef logic [FLOOR_W-1:0] floor_t;
  typedef logic [FLOORS-1:0]  fmask_t;

  typedef enum logic [1:0] {
    DIR_UP   = 2'd0,
    DIR_DOWN = 2'd1,
    DIR_IDLE = 2'd2
  } dir_t;

  localparam floor_t TOP_FLOOR    = floor_t'(FLOORS - 1);
  localparam floor_t GROUND_FLOOR = floor_t'(0);

  typedef struct packed {
    logic   found;
    floor_t idx;
  } hit_t;

  // lowest set bit
  function automatic hit_t lowest_set(input fmask_t m);
    hit_t h;
    h.found = 1'b0;
    h.idx   = '0;
    for (int f = FLOORS - 1; f >= 0; f--) begin
      if (m[f]) begin
        h.found = 1'b1;
        h.idx   = floor_t'(f);
      end
    end
    return h;
  endfunction

  // highest set bit
  function automatic hit_t highest_set(input fmask_t m);
    hit_t h;
    h.found = 1'b0;
    h.idx   = '0;
    for (int f = 0; f < FLOORS; f++) begin
      if (m[f]) begin
        h.found = 1'b1;
        h.idx   = floor_t'(f);
      end
    end
    return h;
  endfunction

  // bit f set where f >= cur
  function automatic fmask_t at_or_above(input floor_t cur);
    fmask_t m;
    for (int f = 0; f < FLOORS; f++) begin
      m[f] = (floor_t'(f) >= cur);
    end
    return m;
  endfunction

endpackage

FILE: hw/rtl/esrs_in_if.sv
`timescale 1ns / 1ps

interface esrs_in_if;
  logic                valid;
  logic                ready;
  esrs_pkg::floor_t    car_floor;
  logic [3:0]          hall_up_presses;
  logic [3:0]          hall_dn_presses;
  logic [3:0]          cab_presses;
  logic                arrived;

  modport source (
    output valid, car_floor, hall_up_presses, hall_dn_presses, cab_presses, arrived,
    input  ready
  );
  modport sink (
    input  valid, car_floor, hall_up_presses, hall_dn_presses, cab_presses, arrived,
    output ready
  );
endinterface

FILE: hw/rtl/esrs_out_if.sv
`timescale 1ns / 1ps

interface esrs_out_if;
  logic                valid;
  logic                ready;
  logic                target_valid;
  esrs_pkg::floor_t    target_floor;
  logic [1:0]          travel_direction;

  modport source (
    output valid, target_valid, target_floor, travel_direction,
    input  ready
  );
  modport sink (
    input  valid, target_valid, target_floor, travel_direction,
    output ready
  );
endinterface

FILE: hw/rtl/elevator_scan_request_selector.sv
`timescale 1ns / 1ps
// an accepted input transaction's result is in the output register in the next cycle
// throughput: one transaction per cycle unless stalled; request selection is one combinational pass
// input ready stays high while the output register is empty or being drained
// reset (synchronous, rst_n low): requests cleared, direction idle, no target, output empty

module elevator_scan_request_selector (
  input  logic       clk,
  input  logic       rst_n,
  esrs_in_if.sink    in_if,
  esrs_out_if.source out_if
);
  import esrs_pkg::*;

  fmask_t hu_r, hd_r, cab_r;
  fmask_t hu_nxt, hd_nxt, cab_nxt;
  dir_t   dir_r, dir_nxt;
  floor_t tgt_r, tgt_nxt;
  logic   pend_r, pend_nxt;
  logic   out_valid_r;

  floor_t cur;
  fmask_t hu_m, hd_m, cab_m, any_m;
  fmask_t ge_m, gt_m, le_m, lt_m, clr_m;
  dir_t   dir_forced;
  hit_t   up_near, up_far, dn_near, dn_far, any_up;
  logic   accept;

  assign accept      = in_if.valid && in_if.ready;
  assign in_if.ready = !out_valid_r || out_if.ready;

  always_comb begin
    cur = (in_if.car_floor > TOP_FLOOR) ? TOP_FLOOR : in_if.car_floor;

    hu_m  = hu_r  | fmask_t'(in_if.hall_up_presses);
    hd_m  = hd_r  | fmask_t'(in_if.hall_dn_presses);
    cab_m = cab_r | fmask_t'(in_if.cab_presses);
    any_m = hu_m | hd_m | cab_m;

    ge_m  = at_or_above(cur);
    lt_m  = ~ge_m;
    clr_m = fmask_t'(1) << cur;
    gt_m  = ge_m & ~clr_m;
    le_m  = lt_m | clr_m;

    up_near = lowest_set((cab_m | hu_m) & ge_m);
    up_far  = highest_set(hd_m & gt_m);
    dn_near = highest_set((cab_m | hd_m) & le_m);
    dn_far  = lowest_set(hu_m & lt_m);
    any_up  = lowest_set(any_m & ge_m);

    // ground check last so it wins where the top floor is also the ground floor
    dir_forced = dir_r;
    if (cur == TOP_FLOOR) dir_forced = DIR_DOWN;
    if (cur == GROUND_FLOOR) dir_forced = DIR_UP;

    dir_nxt  = dir_forced;
    tgt_nxt  = tgt_r;
    pend_nxt = pend_r;

    if (any_m == '0) begin
      dir_nxt = DIR_IDLE;
    end else begin
      case (dir_forced)
        DIR_UP: begin
          if (up_near.found) begin
            tgt_nxt  = up_near.idx;
            pend_nxt = 1'b1;
          end else if (up_far.found) begin
            tgt_nxt  = up_far.idx;
            pend_nxt = 1'b1;
          end else begin
            dir_nxt = DIR_IDLE;
          end
        end
        DIR_DOWN: begin
          if (dn_near.found) begin
            tgt_nxt  = dn_near.idx;
            pend_nxt = 1'b1;
          end else if (dn_far.found) begin
            tgt_nxt  = dn_far.idx;
            pend_nxt = 1'b1;
          end else begin
            dir_nxt = DIR_IDLE;
          end
        end
        default: begin
          // some call exists, so it is either at or above the car or below it
          dir_nxt = any_up.found ? DIR_UP : DIR_DOWN;
        end
      endcase
    end

    hu_nxt  = hu_m;
    hd_nxt  = hd_m;
    cab_nxt = cab_m;
    if (in_if.arrived) begin
      hu_nxt   = hu_m  & ~clr_m;
      hd_nxt   = hd_m  & ~clr_m;
      cab_nxt  = cab_m & ~clr_m;
      tgt_nxt  = '0;
      pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hu_r   <= '0;
      hd_r   <= '0;
      cab_r  <= '0;
      dir_r  <= DIR_IDLE;
      tgt_r  <= '0;
      pend_r <= 1'b0;
    end else if (accept) begin
      hu_r   <= hu_nxt;
      hd_r   <= hd_nxt;
      cab_r  <= cab_nxt;
      dir_r  <= dir_nxt;
      tgt_r  <= tgt_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result fields follow the state registers, which only move on an accepted transaction or at reset
  assign out_if.valid            = out_valid_r;
  assign out_if.target_valid     = pend_r;
  assign out_if.target_floor     = tgt_r;
  assign out_if.travel_direction = dir_r;

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import esrs_pkg::*;

  localparam int RANDOM_TICKS = 1200;
  localparam int DRAIN_LIMIT  = 5000;

  typedef struct packed {
    floor_t cur;
    fmask_t hall_up;
    fmask_t hall_dn;
    fmask_t cab;
    logic   arrived;
  } tick_t;

  typedef struct packed {
    logic   tgt_valid;
    floor_t tgt_floor;
    dir_t   dir;
  } outcome_t;

  typedef struct packed {
    tick_t    tick;
    logic     typed;
    outcome_t want;
  } row_t;

  logic clk;
  logic rst_n;

  esrs_in_if  in_ch ();
  esrs_out_if out_ch ();

  elevator_scan_request_selector uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // predictor state
  fmask_t up_calls;
  fmask_t down_calls;
  fmask_t cab_calls;
  dir_t   sel_dir;
  floor_t sel_target;
  logic   sel_pending;

  outcome_t pending_outcomes[$];
  int       mismatches;
  int       ticks_sent;
  int       outcomes_checked;
  int       targets_seen;
  int       arrivals_sent;
  logic     steady;
  int       hold_left;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #10_000_000;
    $display("timeout at %0t with %0d results outstanding", $time, pending_outcomes.size());
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic fmask_t sparse_press();
    if ($urandom_range(0, 3) == 0) return fmask_t'(1 << $urandom_range(0, FLOORS - 1));
    return '0;
  endfunction

  function automatic outcome_t step_scan_selector(input tick_t t);
    fmask_t   any;
    fmask_t   up_side;
    fmask_t   down_side;
    int       c;
    int       f;
    logic     done;
    outcome_t r;
    c = int'(t.cur);
    up_calls   = up_calls | t.hall_up;
    down_calls = down_calls | t.hall_dn;
    cab_calls  = cab_calls | t.cab;
    any        = up_calls | down_calls | cab_calls;
    up_side    = cab_calls | up_calls;
    down_side  = cab_calls | down_calls;
    done       = 1'b0;

    if (t.cur == TOP_FLOOR) sel_dir = DIR_DOWN;
    if (t.cur == GROUND_FLOOR) sel_dir = DIR_UP;

    if (any == '0) begin
      sel_dir = DIR_IDLE;
    end else if (sel_dir == DIR_UP) begin
      for (f = c; f < FLOORS && !done; f++) begin
        if (up_side[f]) begin
          sel_target = floor_t'(f);
          sel_pending = 1'b1;
          done = 1'b1;
        end
      end
      // fall back to the farthest down call above the car
      for (f = FLOORS - 1; f > c && !done; f--) begin
        if (down_calls[f]) begin
          sel_target = floor_t'(f);
          sel_pending = 1'b1;
          done = 1'b1;
        end
      end
      if (!done) sel_dir = DIR_IDLE;
    end else if (sel_dir == DIR_DOWN) begin
      for (f = c; f >= 0 && !done; f--) begin
        if (down_side[f]) begin
          sel_target = floor_t'(f);
          sel_pending = 1'b1;
          done = 1'b1;
        end
      end
      for (f = 0; f < c && !done; f++) begin
        if (up_calls[f]) begin
          sel_target = floor_t'(f);
          sel_pending = 1'b1;
          done = 1'b1;
        end
      end
      if (!done) sel_dir = DIR_IDLE;
    end else begin
      // idle only picks a direction, the target waits for the next tick
      for (f = c; f < FLOORS && !done; f++) begin
        if (any[f]) begin
          sel_dir = DIR_UP;
          done = 1'b1;
        end
      end
      for (f = c; f >= 0 && !done; f--) begin
        if (any[f]) begin
          sel_dir = DIR_DOWN;
          done = 1'b1;
        end
      end
    end

    if (t.arrived) begin
      up_calls[c]   = 1'b0;
      down_calls[c] = 1'b0;
      cab_calls[c]  = 1'b0;
      sel_pending   = 1'b0;
      sel_target    = '0;
    end

    r.tgt_valid = sel_pending;
    r.tgt_floor = sel_pending ? sel_target : floor_t'(0);
    r.dir       = sel_dir;
    return r;
  endfunction

  // called at a rising edge; returns at the edge where the transaction is taken
  task automatic offer_tick(input tick_t t, input logic typed, input outcome_t want);
    outcome_t p;
    in_ch.valid           <= 1'b1;
    in_ch.car_floor       <= t.cur;
    in_ch.hall_up_presses <= t.hall_up;
    in_ch.hall_dn_presses <= t.hall_dn;
    in_ch.cab_presses     <= t.cab;
    in_ch.arrived         <= t.arrived;
    do @(posedge clk); while (!in_ch.ready);
    p = step_scan_selector(t);
    pending_outcomes.push_back(typed ? want : p);
    ticks_sent++;
    if (t.arrived) arrivals_sent++;
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      in_ch.valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // result side: random backpressure, none during steady stretches
  always @(posedge clk) begin
    if (steady) begin
      out_ch.ready <= 1'b1;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) hold_left <= gap_len();
    end
  end

  always @(posedge clk) begin : check_results
    outcome_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: result transaction with nothing expected: tv=%0d floor=%0d dir=%0d",
                 $time, out_ch.target_valid, out_ch.target_floor, out_ch.travel_direction);
        mismatches++;
      end else begin
        want = pending_outcomes.pop_front();
        outcomes_checked++;
        if (want.tgt_valid) targets_seen++;
        if (out_ch.target_valid !== want.tgt_valid) begin
          $display("%0t: target_valid expected %0d got %0d",
                   $time, want.tgt_valid, out_ch.target_valid);
          mismatches++;
        end
        if (out_ch.target_floor !== want.tgt_floor) begin
          $display("%0t: target_floor expected %0d got %0d",
                   $time, want.tgt_floor, out_ch.target_floor);
          mismatches++;
        end
        if (out_ch.travel_direction !== want.dir) begin
          $display("%0t: travel_direction expected %0d got %0d",
                   $time, want.dir, out_ch.travel_direction);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    row_t   rows [25];
    tick_t  t;
    int     car;
    int     waited;
    outcome_t none;

    none = '{tgt_valid: 1'b0, tgt_floor: floor_t'(0), dir: DIR_IDLE};
    // floor, hall up, hall down, cab, arrived, typed, expected valid / floor / direction
    rows[0]  = '{'{2'd1, 4'h0, 4'h0, 4'h0, 1'b0}, 1'b1, '{1'b0, 2'd0, DIR_IDLE}};
    rows[1]  = '{'{2'd0, 4'h0, 4'h0, 4'h0, 1'b0}, 1'b1, '{1'b0, 2'd0, DIR_IDLE}};
    rows[2]  = '{'{2'd3, 4'h0, 4'h0, 4'h0, 1'b0}, 1'b1, '{1'b0, 2'd0, DIR_IDLE}};
    rows[3]  = '{'{2'd1, 4'h0, 4'h0, 4'h8, 1'b0}, 1'b0, none};
    rows[4]  = '{'{2'd1, 4'h0, 4'h0, 4'h0, 1'b0}, 1'b0, none};
    rows[5]  = '{'{2'd3, 4'h0, 4'h0, 4'h0, 1'b1}, 1'b0, none};
    rows[6]  = '{'{2'd3, 4'h0, 4'h0, 4'h0, 1'b0}, 1'b0, none};
    rows[7]  = '{'{2'd2, 4'h0, 4'h1, 4'h0, 1'b0}, 1'b0, none};
    rows[8]  = '{'{2'd2, 4'h0, 4'h0, 4'h0, 1'b0}, 1'b0, none};
    rows[9]  = '{'{2'd1, 4'h4, 4'h0, 4'h0, 1'b0}, 1'b0, none};
    rows[10] = '{'{2'd0, 4'h0, 4'h0, 4'h0, 1'b1}, 1'b0, none};
    rows[11] = '{'{2'd1, 4'h0, 4'h0, 4'h0, 1'b0}, 1'b0, none};
    rows[12] = '{'{2'd2, 4'h0, 4'h0, 4'h0, 1'b1}, 1'b0, none};
    rows[13] = '{'{2'd2, 4'h0, 4'h0, 4'h0, 1'b0}, 1'b0, none};
    rows[14] = '{'{2'd1, 4'h0, 4'h8, 4'h0, 1'b0}, 1'b0, none};
    rows[15] = '{'{2'd1, 4'h0, 4'h0, 4'h0, 1'b0}, 1'b0, none};
    rows[16] = '{'{2'd2, 4'h1, 4'h0, 4'h0, 1'b0}, 1'b0, none};
    rows[17] = '{'{2'd3, 4'h0, 4'h0, 4'h0, 1'b1}, 1'b0, none};
    rows[18] = '{'{2'd2, 4'h0, 4'h0, 4'h0, 1'b0}, 1'b0, none};
    rows[19] = '{'{2'd0, 4'h0, 4'h0, 4'h0, 1'b1}, 1'b0, none};
    rows[20] = '{'{2'd2, 4'h0, 4'h0, 4'h1, 1'b0}, 1'b0, none};
    rows[21] = '{'{2'd2, 4'h0, 4'h0, 4'h0, 1'b0}, 1'b0, none};
    rows[22] = '{'{2'd0, 4'h0, 4'h0, 4'h0, 1'b1}, 1'b0, none};
    rows[23] = '{'{2'd1, 4'hf, 4'hf, 4'hf, 1'b0}, 1'b0, none};
    rows[24] = '{'{2'd1, 4'hf, 4'hf, 4'hf, 1'b1}, 1'b0, none};

    up_calls    = '0;
    down_calls  = '0;
    cab_calls   = '0;
    sel_dir     = DIR_IDLE;
    sel_target  = '0;
    sel_pending = 1'b0;
    mismatches = 0;
    ticks_sent = 0;
    outcomes_checked = 0;
    targets_seen = 0;
    arrivals_sent = 0;
    steady = 1'b0;
    hold_left = 0;
    car = 0;

    rst_n                 = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.car_floor       = '0;
    in_ch.hall_up_presses = '0;
    in_ch.hall_dn_presses = '0;
    in_ch.cab_presses     = '0;
    in_ch.arrived         = 1'b0;
    out_ch.ready          = 1'b0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      offer_tick(rows[i].tick, rows[i].typed, rows[i].want);
      pause_sender(gap_len());
    end

    for (int i = 0; i < RANDOM_TICKS; i++) begin
      steady = (i % 400) >= 320;
      if ($urandom_range(0, 99) < 15) begin
        // noise: any floor, any presses, arrival at random
        t.cur       = floor_t'($urandom_range(0, FLOORS - 1));
        t.hall_up   = fmask_t'($urandom);
        t.hall_dn   = fmask_t'($urandom);
        t.cab       = fmask_t'($urandom);
        t.arrived   = 1'($urandom_range(0, 1));
        car = int'(t.cur);
      end else begin
        // car drifts toward its target and usually stops there
        if (sel_pending && car != int'(sel_target) && $urandom_range(0, 1) == 1)
          car += (int'(sel_target) > car) ? 1 : -1;
        t.cur       = floor_t'(car);
        t.hall_up   = sparse_press();
        t.hall_dn   = sparse_press();
        t.cab       = sparse_press();
        t.arrived   = sel_pending && car == int'(sel_target) && $urandom_range(0, 9) < 7;
      end
      offer_tick(t, 1'b0, none);
      if (i == RANDOM_TICKS / 2) begin
        // let the result side drain completely before going on
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_outcomes.size() != 0);
      end else begin
        pause_sender(steady ? 0 : gap_len());
      end
    end

    steady = 1'b0;
    in_ch.valid <= 1'b0;
    waited = 0;
    while (pending_outcomes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (pending_outcomes.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_outcomes.size());
      mismatches += pending_outcomes.size();
    end

    $display("sent %0d ticks (%0d arrivals), checked %0d results, %0d with a pending target",
             ticks_sent, arrivals_sent, outcomes_checked, targets_seen);
    $display("field mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/esrs_pkg.sv
hw/rtl/esrs_in_if.sv
hw/rtl/esrs_out_if.sv
hw/rtl/elevator_scan_request_selector.sv
bench/testbench.sv
